FILE: rtl/tgd_pkg.sv
package tgd_pkg;

    // Table and field geometry
    localparam int MEMBER_SLOTS = 64;
    localparam int COORD_BITS   = 10;
    localparam int IDX_W        = 6;
    localparam int ADDR_W       = $clog2(MEMBER_SLOTS);
    localparam int REG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int DIST_W       = 11;

    // Signed axis delta: |diff| - full can reach -(2**REG_W - 2)
    localparam int DELTA_W = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
    localparam int SQ_W    = 2 * (DELTA_W - 1);
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int CNT_W   = $clog2(ROOT_W + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [REG_W-1:0] MAP_WIDTH_RST   = REG_W'(1024);
    localparam logic [REG_W-1:0] MAP_HEIGHT_RST  = REG_W'(1024);
    localparam logic [REG_W-1:0] HALF_WIDTH_RST  = REG_W'(512);
    localparam logic [REG_W-1:0] HALF_HEIGHT_RST = REG_W'(512);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH   = 2'd0,
        CFG_MAP_HEIGHT  = 2'd1,
        CFG_HALF_WIDTH  = 2'd2,
        CFG_HALF_HEIGHT = 2'd3
    } t_cfg_reg;

endpackage

FILE: rtl/tgd_mem.sv
module tgd_mem
    import tgd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic [2*COORD_BITS-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [ADDR_W-1:0]       i_raddr_a,
    input  logic [ADDR_W-1:0]       i_raddr_b,
    output logic [2*COORD_BITS-1:0] o_rdata_a,
    output logic [2*COORD_BITS-1:0] o_rdata_b
);

    // {col, row} per member, one write port, two registered read ports
    logic [2*COORD_BITS-1:0] mem [MEMBER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

FILE: rtl/tgd_isqrt.sv
module tgd_isqrt
    import tgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_radicand,
    output logic              o_busy,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    // Digit-by-digit root, one result bit per cycle
    localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (2 * (ROOT_W - 1));

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_root;
    logic [SUM_W-1:0] r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] cand;

    assign cand = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_rem  <= i_radicand;
                r_root <= '0;
                r_bit  <= BIT_START;
                r_cnt  <= CNT_W'(ROOT_W);
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                if (r_rem >= cand) begin
                    r_rem  <= r_rem - cand;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

FILE: rtl/toroidal_grid_distance.sv
// Toroidal grid distance
//
// Input channel (i_in_valid / o_in_ready) carries one item per transfer.
// op = write stores (column, row) at index_a in a 64-entry table and
// gives no result. op = query reads entries index_a and
// index_b, forms the wrapped column and row deltas, and returns the floor of
// the Euclidean distance on the output channel (o_out_valid / i_out_ready).
//
// A query passes through the table read at the transfer, the delta and
// square registers, the sum step, 12 square-root steps and the output load;
// the next item is taken only once the block is back in idle. The 12-step
// root unit works one result bit a cycle. Writes go back to back.
//
// Config writes (i_cfg_wr_en) land at once; write them only while idle.
// Reset restores map 1024 x 1024 with half extents 512 and clears all
// control state; table contents stay undefined until written.
// A stalled receiver holds the result in the output register; a new item is
// still taken, and a second query waits at its end until that slot frees.
module toroidal_grid_distance
    import tgd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [IDX_W-1:0]     i_index_a,
    input  logic [IDX_W-1:0]     i_index_b,
    input  logic [COORD_BITS-1:0] i_pos_col,
    input  logic [COORD_BITS-1:0] i_pos_row,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DIST_W-1:0]    o_distance,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [REG_W-1:0] r_map_width;
    logic [REG_W-1:0] r_map_height;
    logic [REG_W-1:0] r_half_width;
    logic [REG_W-1:0] r_half_height;

    logic r_a_ok;
    logic r_b_ok;
    logic signed [DELTA_W-1:0] r_dc;
    logic signed [DELTA_W-1:0] r_dr;
    logic [SQ_W-1:0] r_sq_c;
    logic [SQ_W-1:0] r_sq_r;
    logic            r_out_valid;
    logic [DIST_W-1:0] r_distance;

    logic in_fire;
    logic a_in_range;
    logic b_in_range;
    logic mem_we;
    logic mem_re;
    logic [2*COORD_BITS-1:0] rd_a;
    logic [2*COORD_BITS-1:0] rd_b;
    logic [COORD_BITS-1:0] a_col, a_row, b_col, b_row;
    logic signed [DELTA_W-1:0] dc, dr;
    logic signed [2*DELTA_W-1:0] prod_c, prod_r;
    logic sqrt_start, sqrt_busy, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [DIST_W-1:0] root_sat;
    logic out_free;
    logic out_load;

    // Absolute difference, then one wrap by the full extent past the half
    function automatic logic signed [DELTA_W-1:0] axis_delta(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q,
        input logic [REG_W-1:0]      half,
        input logic [REG_W-1:0]      full
    );
        logic [COORD_BITS-1:0] diff;
        logic [DELTA_W-2:0]    diff_x;
        logic [DELTA_W-2:0]    half_x;
        logic [DELTA_W-2:0]    full_x;
        diff   = (p >= q) ? (p - q) : (q - p);
        diff_x = (DELTA_W-1)'(diff);
        half_x = (DELTA_W-1)'(half);
        full_x = (DELTA_W-1)'(full);
        if (diff_x > half_x) begin
            return $signed({1'b0, diff_x}) - $signed({1'b0, full_x});
        end
        return $signed({1'b0, diff_x});
    endfunction

    assign in_fire    = i_in_valid && o_in_ready;
    assign a_in_range = 32'(i_index_a) < MEMBER_SLOTS;
    assign b_in_range = 32'(i_index_b) < MEMBER_SLOTS;
    assign mem_we     = in_fire && (i_op == OP_WRITE) && a_in_range;
    assign mem_re     = in_fire && (i_op == OP_QUERY);

    tgd_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (ADDR_W'(i_index_a)),
        .i_wdata   ({i_pos_col, i_pos_row}),
        .i_re      (mem_re),
        .i_raddr_a (ADDR_W'(i_index_a)),
        .i_raddr_b (ADDR_W'(i_index_b)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Entries past the table read as zero
    assign a_col = r_a_ok ? rd_a[2*COORD_BITS-1:COORD_BITS] : '0;
    assign a_row = r_a_ok ? rd_a[COORD_BITS-1:0]            : '0;
    assign b_col = r_b_ok ? rd_b[2*COORD_BITS-1:COORD_BITS] : '0;
    assign b_row = r_b_ok ? rd_b[COORD_BITS-1:0]            : '0;

    assign dc = axis_delta(a_col, b_col, r_half_width, r_map_width);
    assign dr = axis_delta(a_row, b_row, r_half_height, r_map_height);

    assign prod_c = r_dc * r_dc;
    assign prod_r = r_dr * r_dr;

    assign sqrt_start = (r_state == S_SUM);

    tgd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (SUM_W'(r_sq_c) + SUM_W'(r_sq_r)),
        .o_busy     (sqrt_busy),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign root_sat = (sqrt_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sqrt_root);
    assign out_free = !r_out_valid || i_out_ready;
    // Result moves into the output register this cycle
    assign out_load = out_free && (((r_state == S_ROOT) && sqrt_done) || (r_state == S_DONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_map_width   <= MAP_WIDTH_RST;
            r_map_height  <= MAP_HEIGHT_RST;
            r_half_width  <= HALF_WIDTH_RST;
            r_half_height <= HALF_HEIGHT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                    CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                    CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data;
                    CFG_HALF_HEIGHT: r_half_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_op == OP_QUERY)) begin
                        r_a_ok  <= a_in_range;
                        r_b_ok  <= b_in_range;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_dc    <= dc;
                    r_dr    <= dr;
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_sq_c  <= prod_c[SQ_W-1:0];
                    r_sq_r  <= prod_r[SQ_W-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sqrt_done) begin
                        if (out_free) begin
                            r_distance  <= root_sat;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_distance  <= root_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;

    // Root unit is never restarted mid-run
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("root unit started while busy");

    // Root finishes only while the sequencer waits for it
    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("root done outside root wait");

    // A table write never starts a computation
    a_write_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_op == OP_WRITE)) |=> (r_state == S_IDLE))
        else $error("write item left idle");

    // A pending result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_distance)))
        else $error("pending result overwritten");

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import tgd_pkg::*;

    // Pause after the last expected result before touching config or ending;
    // it is long enough to cover the pipe.
    localparam int DRAIN_CYCLES = 24;
    // Worst case per item is a busy query plus a full sender gap and receiver
    // stall, for under 2000 items; this limit is several times that.
    localparam int RUN_LIMIT    = 4_000_000;
    localparam int PHASE_ITEMS  = 270;
    localparam int FINAL_ITEMS  = 120;
    localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
    localparam int REG_TOP      = (1 << REG_W) - 1;

    typedef struct packed {
        t_op                   op;
        logic [IDX_W-1:0]      index_a;
        logic [IDX_W-1:0]      index_b;
        logic [COORD_BITS-1:0] pos_col;
        logic [COORD_BITS-1:0] pos_row;
    } t_grid_item;

    // DUT ports; the inputs are all at known values from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_op        = 1'b0;
    logic [IDX_W-1:0]      i_index_a   = '0;
    logic [IDX_W-1:0]      i_index_b   = '0;
    logic [COORD_BITS-1:0] i_pos_col   = '0;
    logic [COORD_BITS-1:0] i_pos_row   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [DIST_W-1:0]     o_distance;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [REG_W-1:0]      i_cfg_data  = '0;

    toroidal_grid_distance dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_pos_col   (i_pos_col),
        .i_pos_row   (i_pos_row),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4-unit clock: 2 high, 2 low
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: member table, config shadow, expected distances
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] member_col_tab [MEMBER_SLOTS];
    logic [COORD_BITS-1:0] member_row_tab [MEMBER_SLOTS];
    bit                    slot_loaded    [MEMBER_SLOTS];
    int                    loaded_slots   [$];   // slots safe to query

    logic [REG_W-1:0] map_w_shadow  = MAP_WIDTH_RST;
    logic [REG_W-1:0] map_h_shadow  = MAP_HEIGHT_RST;
    logic [REG_W-1:0] half_w_shadow = HALF_WIDTH_RST;
    logic [REG_W-1:0] half_h_shadow = HALF_HEIGHT_RST;

    logic [DIST_W-1:0] pending_distances [$];
    logic [DIST_W-1:0] oldest_distance;
    int                error_count = 0;
    bit                idle_on     = 1'b1;      // random idling on both sides

    // Exact floor square root, two bits of the radicand per step
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // |p - q|, minus the full extent once when past the half extent.
    // May go negative; it gets squared anyway.
    function automatic longint wrapped_delta(int unsigned p, int unsigned q,
                                             int unsigned half, int unsigned full);
        longint d;
        d = longint'(p) - longint'(q);
        if (d < 0)
            d = -d;
        if (d > longint'(half))
            d = d - longint'(full);
        return d;
    endfunction

    function automatic logic [DIST_W-1:0] toroidal_distance(int unsigned a, int unsigned b);
        longint          dc;
        longint          dr;
        longint unsigned root;
        dc   = wrapped_delta(32'(member_col_tab[a]), 32'(member_col_tab[b]),
                             32'(half_w_shadow), 32'(map_w_shadow));
        dr   = wrapped_delta(32'(member_row_tab[a]), 32'(member_row_tab[b]),
                             32'(half_h_shadow), 32'(map_h_shadow));
        root = floor_sqrt(longint'(dc * dc) + longint'(dr * dr));
        if (root > longint'(DIST_MAX))
            root = 64'(DIST_MAX);
        return root[DIST_W-1:0];
    endfunction

    // Apply one accepted item to the predictor
    task automatic track_transfer(t_grid_item it);
        if (it.op == OP_WRITE) begin
            member_col_tab[it.index_a] = it.pos_col;
            member_row_tab[it.index_a] = it.pos_row;
            if (!slot_loaded[it.index_a]) begin
                slot_loaded[it.index_a] = 1'b1;
                loaded_slots.push_back(int'(it.index_a));
            end
        end else begin
            pending_distances.push_back(toroidal_distance(32'(it.index_a),
                                                          32'(it.index_b)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge.
    // Valid stays high between back-to-back items, payload just changes.
    // ------------------------------------------------------------------
    task automatic send_item(t_grid_item it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap        = $urandom_range(1, 14);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op       = it.op;
        i_index_a  = it.index_a;
        i_index_b  = it.index_b;
        i_pos_col  = it.pos_col;
        i_pos_row  = it.pos_row;
        i_in_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_in_ready)
                break;
            @(negedge i_clk);
        end
        track_transfer(it);
        @(negedge i_clk);
    endtask

    // Table load; index_b is don't-care, so it gets noise
    task automatic send_write(int unsigned idx, int unsigned col, int unsigned row);
        t_grid_item it;
        it.op       = OP_WRITE;
        it.index_a  = idx[IDX_W-1:0];
        it.index_b  = IDX_W'($urandom_range(0, MEMBER_SLOTS - 1));
        it.pos_col  = col[COORD_BITS-1:0];
        it.pos_row  = row[COORD_BITS-1:0];
        send_item(it);
    endtask

    // Distance query; coordinates are don't-care, so they get noise
    task automatic send_query(int unsigned a, int unsigned b);
        t_grid_item it;
        it.op       = OP_QUERY;
        it.index_a  = a[IDX_W-1:0];
        it.index_b  = b[IDX_W-1:0];
        it.pos_col  = COORD_BITS'($urandom_range(0, COORD_TOP));
        it.pos_row  = COORD_BITS'($urandom_range(0, COORD_TOP));
        send_item(it);
    endtask

    // Sender holds off until every expected distance is back, then lets
    // the pipe settle (trailing writes give no result to wait on).
    task automatic wait_quiet();
        i_in_valid = 1'b0;
        while (pending_distances.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // All four registers, back to back, only once the block is idle
    task automatic write_config(int unsigned w, int unsigned h,
                                int unsigned hw, int unsigned hh);
        t_cfg_reg    regs [4];
        int unsigned vals [4];
        wait_quiet();
        regs = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_HALF_WIDTH, CFG_HALF_HEIGHT};
        vals = '{w, h, hw, hh};
        i_cfg_wr_en = 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_index = regs[i];
            i_cfg_data  = vals[i][REG_W-1:0];
            case (regs[i])
                CFG_MAP_WIDTH:   map_w_shadow  = vals[i][REG_W-1:0];
                CFG_MAP_HEIGHT:  map_h_shadow  = vals[i][REG_W-1:0];
                CFG_HALF_WIDTH:  half_w_shadow = vals[i][REG_W-1:0];
                CFG_HALF_HEIGHT: half_h_shadow = vals[i][REG_W-1:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_wr_en = 1'b0;
    endtask

    // Coordinates lean toward the edges of the map
    function automatic int unsigned pick_coord();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return COORD_TOP;
            default: return $urandom_range(0, COORD_TOP);
        endcase
    endfunction

    // Register values: mostly in the usual range, some at or past its ends
    function automatic int unsigned pick_extent(bit is_half);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return REG_TOP;
            2:       return 1024;
            3:       return $urandom_range(0, REG_TOP);
            default: return is_half ? $urandom_range(0, 1024) : $urandom_range(1, 1024);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts while idling is on
    // ------------------------------------------------------------------
    initial begin : out_ready_gen
        int stall;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                stall       = $urandom_range(1, 14);
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    // Result checker: every output transfer pops the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_distances.size() == 0) begin
                $error("unexpected result: distance %0d", o_distance);
                error_count++;
            end else begin
                oldest_distance = pending_distances.pop_front();
                if (o_distance !== oldest_distance) begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           oldest_distance, o_distance);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner coordinates under the reset map (1024 x 1024, halves 512)
    task automatic test_table_corners();
        send_write(0, 0, 0);
        send_write(MEMBER_SLOTS - 1, COORD_TOP, COORD_TOP);
        send_write(1, 0, COORD_TOP);
        send_write(2, COORD_TOP, 0);
        send_write(3, 512, 512);
        send_write(4, 511, 0);
        send_write(5, 1, 1);
        send_query(0, MEMBER_SLOTS - 1);   // both axes wrap to -1
        send_query(MEMBER_SLOTS - 1, 0);
        send_query(0, 0);                  // same entry, zero
        send_query(1, 2);
        send_query(0, 3);                  // difference equal to half: no wrap
        send_query(3, 4);
        send_query(4, 0);                  // just under half
    endtask

    // Register extremes: tiny map, no-wrap halves, zero map, saturation
    task automatic test_config_extremes();
        write_config(1, 1, 0, 0);
        send_query(0, MEMBER_SLOTS - 1);
        send_query(1, 2);
        // wrap subtracts the full 11-bit width; a near pair saturates
        write_config(REG_TOP, REG_TOP, 0, 0);
        send_query(0, 5);
        send_query(0, MEMBER_SLOTS - 1);
        write_config(0, 0, 0, 0);          // wrap subtracts nothing
        send_query(0, MEMBER_SLOTS - 1);
        write_config(REG_TOP, REG_TOP, REG_TOP, REG_TOP);
        send_query(1, 2);
        write_config(MAP_WIDTH_RST, MAP_HEIGHT_RST, HALF_WIDTH_RST, HALF_HEIGHT_RST);
    endtask

    // Random loads and queries over several register settings
    task automatic test_random_phases();
        int unsigned w;
        int unsigned h;
        int unsigned hw;
        int unsigned hh;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                w  = pick_extent(1'b0);
                h  = pick_extent(1'b0);
                // half is often the true half so the wrap means something
                hw = ($urandom_range(0, 1) == 0) ? w / 2 : pick_extent(1'b1);
                hh = ($urandom_range(0, 1) == 0) ? h / 2 : pick_extent(1'b1);
                write_config(w, h, hw, hh);
            end
            idle_on = (ph != 3);               // one phase runs flat out
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_quiet();              // sender drains mid-phase
                if (loaded_slots.size() == 0 || $urandom_range(0, 99) < 35) begin
                    send_write($urandom_range(0, MEMBER_SLOTS - 1), pick_coord(), pick_coord());
                end else begin
                    send_query(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                               loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
                end
            end
        end
    endtask

    // Last stretch with no idling on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_config(MAP_WIDTH_RST, MAP_HEIGHT_RST, HALF_WIDTH_RST, HALF_HEIGHT_RST);
        for (int n = 0; n < FINAL_ITEMS; n++) begin
            if ($urandom_range(0, 3) == 0)
                send_write($urandom_range(0, MEMBER_SLOTS - 1), pick_coord(), pick_coord());
            else
                send_query(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                           loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        end
    endtask

    initial begin
        // reset: held low, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_corners();
        test_config_extremes();
        test_random_phases();
        test_back_to_back();

        wait_quiet();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
